>>> hdl/cbts_pkg.sv
// ----------------------------------------------------------------------------
// cbts_pkg: shared types and constants for the CAN bit timing search
// Field widths, argument limits, status codes and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cbts_pkg;

	localparam int OSC_W  = 26;
	localparam int RATE_W = 21;
	localparam int SP_W   = 10;
	localparam int TQ_W   = 9;
	localparam int DIV_W  = OSC_W + 1;
	localparam int CNT_W  = 5;
	localparam int ERR_W  = 19;
	localparam int PROD_W = ERR_W + TQ_W;

	localparam int OSC_MIN    = 2000000;
	localparam int OSC_MAX    = 40000000;
	localparam int RATE_MIN   = 5000;
	localparam int RATE_MAX   = 1000000;
	localparam int SP_LIMIT   = 1000;
	localparam int SP_DEFAULT = 875;
	localparam int TQ_MIN     = 4;
	localparam int TQ_MAX     = 385;
	localparam int PHASE1_MAX = 256;
	localparam int PERMILL    = 1000;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_NOFIT = 2'd2;

	typedef struct packed {
		logic load;
		logic init_brp;
		logic next_brp;
		logic div_start;
		logic div_step;
		logic ph_init;
		logic ph_mul;
		logic take;
		logic ph_adv;
	} cmd_t;

	typedef struct packed {
		logic range_ok;
		logic stop_brp;
		logic div_last;
		logic qual_ok;
		logic loop_ok;
		logic seg1_ok;
		logic better;
		logic found;
	} sts_t;

endpackage

>>> hdl/cbts_dp.sv
// ----------------------------------------------------------------------------
// cbts_dp: datapath of the CAN bit timing search
// Prescaler stepping, a one-bit-per-cycle restoring divider, the phase-2
// sweep with cross-multiplied error compare, and the best-candidate registers.
// ----------------------------------------------------------------------------
module cbts_dp #(
	parameter int MAX_PRESCALER = 256,
	parameter int MAX_PHASE2    = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cbts_pkg::cmd_t                cmd,
	output cbts_pkg::sts_t                sts,
	input  logic [cbts_pkg::OSC_W-1:0]    osc_freq,
	input  logic [cbts_pkg::RATE_W-1:0]   bit_rate,
	input  logic [cbts_pkg::SP_W-1:0]     sample_permill,
	output logic [7:0]                    prescaler_m1,
	output logic [7:0]                    phase1_m1,
	output logic [6:0]                    phase2_m1,
	output logic [6:0]                    jump_width_m1
);

	localparam int BRP_W  = $clog2(MAX_PRESCALER + 2);
	localparam int SEG2_W = $clog2(MAX_PHASE2 + 2);
	localparam int CMP_W  = ((SEG2_W > cbts_pkg::TQ_W) ? SEG2_W : cbts_pkg::TQ_W) + 1;

	logic [cbts_pkg::OSC_W-1:0]  osc_q;
	logic [cbts_pkg::RATE_W-1:0] rate_q;
	logic [cbts_pkg::SP_W-1:0]   sp_q;
	logic                        range_ok_q;

	logic [BRP_W-1:0]            brp_q;
	logic [cbts_pkg::DIV_W-1:0]  div_q;
	logic [cbts_pkg::DIV_W-1:0]  rem_q;
	logic [cbts_pkg::OSC_W-1:0]  quot_q;
	logic [cbts_pkg::CNT_W-1:0]  cnt_q;

	logic [cbts_pkg::TQ_W-1:0]   tq_q;
	logic [SEG2_W-1:0]           seg2_q;
	logic [cbts_pkg::ERR_W-1:0]  a_q;
	logic [cbts_pkg::ERR_W-1:0]  b_q;
	logic [cbts_pkg::ERR_W-1:0]  err_q;
	logic [cbts_pkg::PROD_W-1:0] pn_q;
	logic [cbts_pkg::PROD_W-1:0] pb_q;

	logic                        found_q;
	logic [cbts_pkg::ERR_W-1:0]  best_err_q;
	logic [cbts_pkg::TQ_W-1:0]   best_tq_q;

	logic [cbts_pkg::DIV_W:0]    trial;
	logic                        trial_ge;
	logic [cbts_pkg::TQ_W-1:0]   tq_n;
	logic [cbts_pkg::ERR_W-1:0]  err_c;
	logic [CMP_W-1:0]            seg2_x;
	logic [CMP_W-1:0]            tq_x;
	logic [CMP_W-1:0]            seg1;
	logic [CMP_W-1:0]            seg_min;
	logic [BRP_W-1:0]            brp_m1;
	logic                        in_ok;

	assign in_ok = (osc_freq >= cbts_pkg::OSC_W'(cbts_pkg::OSC_MIN))
		&& (osc_freq <= cbts_pkg::OSC_W'(cbts_pkg::OSC_MAX))
		&& (bit_rate >= cbts_pkg::RATE_W'(cbts_pkg::RATE_MIN))
		&& (bit_rate <= cbts_pkg::RATE_W'(cbts_pkg::RATE_MAX))
		&& (sample_permill < cbts_pkg::SP_W'(cbts_pkg::SP_LIMIT));

	// restoring divide: shift in one dividend bit, subtract when it fits
	assign trial    = {rem_q, osc_q[cnt_q]};
	assign trial_ge = trial >= {1'b0, div_q};
	assign tq_n     = quot_q[cbts_pkg::TQ_W-1:0];

	assign err_c   = (a_q >= b_q) ? (a_q - b_q) : (b_q - a_q);
	assign seg2_x  = CMP_W'(seg2_q);
	assign tq_x    = CMP_W'(tq_q);
	assign seg1    = tq_x - seg2_x - CMP_W'(1);
	assign seg_min = (seg2_x < seg1) ? seg2_x : seg1;
	assign brp_m1  = brp_q - BRP_W'(1);

	always_comb begin
		sts.range_ok = range_ok_q;
		sts.stop_brp = (brp_q > BRP_W'(MAX_PRESCALER))
			|| (div_q > cbts_pkg::DIV_W'(osc_q));
		sts.div_last = (cnt_q == '0);
		sts.qual_ok  = (rem_q == '0)
			&& (quot_q >= cbts_pkg::OSC_W'(cbts_pkg::TQ_MIN))
			&& (quot_q <= cbts_pkg::OSC_W'(cbts_pkg::TQ_MAX));
		sts.loop_ok  = (seg2_q <= SEG2_W'(MAX_PHASE2)) && ((seg2_x + CMP_W'(2)) < tq_x);
		sts.seg1_ok  = seg1 <= CMP_W'(cbts_pkg::PHASE1_MAX);
		sts.better   = !found_q || (pn_q < pb_q);
		sts.found    = found_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.init_brp) begin
			found_q <= 1'b0;
		end else if (cmd.take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			osc_q      <= osc_freq;
			rate_q     <= bit_rate;
			sp_q       <= (sample_permill == '0) ?
				cbts_pkg::SP_W'(cbts_pkg::SP_DEFAULT) : sample_permill;
			range_ok_q <= in_ok;
		end
		if (cmd.init_brp) begin
			brp_q <= BRP_W'(1);
			div_q <= cbts_pkg::DIV_W'(rate_q);
		end else if (cmd.next_brp) begin
			brp_q <= brp_q + BRP_W'(1);
			div_q <= div_q + cbts_pkg::DIV_W'(rate_q);
		end
		if (cmd.div_start) begin
			rem_q  <= '0;
			quot_q <= '0;
			cnt_q  <= cbts_pkg::CNT_W'(cbts_pkg::OSC_W - 1);
		end else if (cmd.div_step) begin
			rem_q  <= trial_ge ? cbts_pkg::DIV_W'(trial - {1'b0, div_q})
				: trial[cbts_pkg::DIV_W-1:0];
			quot_q <= {quot_q[cbts_pkg::OSC_W-2:0], trial_ge};
			cnt_q  <= cnt_q - cbts_pkg::CNT_W'(1);
		end
		if (cmd.ph_init) begin
			tq_q   <= tq_n;
			seg2_q <= SEG2_W'(1);
			a_q    <= cbts_pkg::ERR_W'(tq_n - cbts_pkg::TQ_W'(1))
				* cbts_pkg::ERR_W'(cbts_pkg::PERMILL);
			b_q    <= cbts_pkg::ERR_W'(sp_q) * cbts_pkg::ERR_W'(tq_n);
		end else if (cmd.ph_adv) begin
			seg2_q <= seg2_q + SEG2_W'(1);
			a_q    <= a_q - cbts_pkg::ERR_W'(cbts_pkg::PERMILL);
		end
		if (cmd.ph_mul) begin
			err_q <= err_c;
			pn_q  <= cbts_pkg::PROD_W'(err_c) * cbts_pkg::PROD_W'(best_tq_q);
			pb_q  <= cbts_pkg::PROD_W'(best_err_q) * cbts_pkg::PROD_W'(tq_q);
		end
		if (cmd.take) begin
			best_err_q    <= err_q;
			best_tq_q     <= tq_q;
			prescaler_m1  <= 8'(brp_m1);
			phase1_m1     <= 8'(seg1 - CMP_W'(1));
			phase2_m1     <= 7'(seg2_x - CMP_W'(1));
			jump_width_m1 <= 7'(seg_min - CMP_W'(1));
		end
	end

endmodule

>>> hdl/cbts_ctrl.sv
// ----------------------------------------------------------------------------
// cbts_ctrl: controller of the CAN bit timing search
// Sequences argument check, prescaler sweep, divide and phase-2 sweep, and
// hands the final status to the output stage.
// ----------------------------------------------------------------------------
module cbts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           out_free,
	output logic           pub,
	output logic [1:0]     code,
	output cbts_pkg::cmd_t cmd,
	input  cbts_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RANGE,
		S_CHECK,
		S_DIV,
		S_QUAL,
		S_PH_MUL,
		S_PH_CMP,
		S_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] code_q;

	assign in_ready = (state_q == S_IDLE);
	assign pub      = (state_q == S_DONE) && out_free;
	assign code     = code_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.load = in_valid;
			S_RANGE:  cmd.init_brp = sts.range_ok;
			S_CHECK:  cmd.div_start = !sts.stop_brp;
			S_DIV:    cmd.div_step = 1'b1;
			S_QUAL: begin
				cmd.ph_init  = sts.qual_ok;
				cmd.next_brp = !sts.qual_ok;
			end
			S_PH_MUL: cmd.ph_mul = 1'b1;
			S_PH_CMP: begin
				cmd.next_brp = !sts.loop_ok;
				cmd.take     = sts.loop_ok && sts.seg1_ok && sts.better;
				cmd.ph_adv   = sts.loop_ok;
			end
			S_DONE:   cmd = '0;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= cbts_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_RANGE;
				end
				S_RANGE: begin
					if (sts.range_ok) begin
						state_q <= S_CHECK;
					end else begin
						code_q  <= cbts_pkg::ST_RANGE;
						state_q <= S_DONE;
					end
				end
				S_CHECK: begin
					// divisor past the clock means no later prescaler fits either
					if (sts.stop_brp) begin
						code_q  <= sts.found ? cbts_pkg::ST_OK : cbts_pkg::ST_NOFIT;
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (sts.div_last) state_q <= S_QUAL;
				end
				S_QUAL: begin
					state_q <= sts.qual_ok ? S_PH_MUL : S_CHECK;
				end
				S_PH_MUL: state_q <= S_PH_CMP;
				S_PH_CMP: begin
					state_q <= sts.loop_ok ? S_PH_MUL : S_CHECK;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/can_bit_timing_search.sv
// ----------------------------------------------------------------------------
// can_bit_timing_search: CAN nominal bit timing search
// One request word (oscillator, bitrate, sample point) gives one result word
// (status, prescaler, phase 1, phase 2, jump width, all minus one). A request
// passes the argument check, then for each prescaler tried a stop check, a
// restoring divide of the 26-bit clock at one dividend bit per cycle and a
// qualify step, plus a multiply and a compare per phase-2 length for each
// prescaler that divides the clock exactly; the sweep ends early once
// bitrate times prescaler exceeds the clock. The next request is taken
// once the result is in the output register.
// ----------------------------------------------------------------------------
module can_bit_timing_search #(
	parameter int MAX_PRESCALER = 256,
	parameter int MAX_PHASE2    = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [25:0] osc_freq, [46:26] bit_rate, [56:47] sample_permill, rest zero
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] prescaler_m1, [15:8] phase1_m1, [22:16] phase2_m1,
	// [29:23] jump_width_m1, rest zero
	output logic [31:0] m_tdata,
	// [1:0] status
	output logic [1:0]  m_tuser
);

	cbts_pkg::cmd_t cmd;
	cbts_pkg::sts_t sts;
	logic           out_free;
	logic           pub;
	logic [1:0]     code;
	logic [7:0]     prescaler_m1;
	logic [7:0]     phase1_m1;
	logic [6:0]     phase2_m1;
	logic [6:0]     jump_width_m1;
	logic           m_tvalid_q;
	logic [31:0]    m_tdata_q;
	logic [1:0]     m_tuser_q;

	assign out_free = !m_tvalid_q || m_tready;

	cbts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_free (out_free),
		.pub      (pub),
		.code     (code),
		.cmd      (cmd),
		.sts      (sts)
	);

	cbts_dp #(
		.MAX_PRESCALER (MAX_PRESCALER),
		.MAX_PHASE2    (MAX_PHASE2)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.osc_freq       (s_tdata[25:0]),
		.bit_rate       (s_tdata[46:26]),
		.sample_permill (s_tdata[56:47]),
		.prescaler_m1   (prescaler_m1),
		.phase1_m1      (phase1_m1),
		.phase2_m1      (phase2_m1),
		.jump_width_m1  (jump_width_m1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (pub) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// zero the timing fields on any failing status
	always_ff @(posedge clk) begin
		if (pub) begin
			m_tuser_q <= code;
			if (code == cbts_pkg::ST_OK) begin
				m_tdata_q <= {2'b00, jump_width_m1, phase2_m1, phase1_m1, prescaler_m1};
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

>>> verif/tb_can_bit_timing_search.sv
// ----------------------------------------------------------------------------
// tb_can_bit_timing_search: self-checking bench for the CAN bit timing search
// Drives request words (oscillator, bitrate, sample point) into the block and
// checks every result word against a local timing search over the same
// prescaler and phase ranges. Directed limits and edges first, then random requests
// under several idle and stall mixes, then a long output hold-off.
// ----------------------------------------------------------------------------
module tb_can_bit_timing_search;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PRESCALER = 256;
	localparam int MAX_PHASE2    = 128;
	localparam longint unsigned CYCLE_LIMIT = 40_000_000;
	localparam int HOLD_CYCLES   = 600;
	localparam int RANDOM_ITEMS  = 17;
	localparam int unsigned COMMON_RATES [8] =
		'{5000, 10000, 20000, 50000, 125000, 250000, 500000, 1000000};

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] prescaler_m1;
		logic [7:0] phase1_m1;
		logic [6:0] phase2_m1;
		logic [6:0] jump_width_m1;
	} bit_timing_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// [25:0] osc_freq, [46:26] bit_rate, [56:47] sample_permill, rest zero
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// [7:0] prescaler_m1, [15:8] phase1_m1, [22:16] phase2_m1,
	// [29:23] jump_width_m1, rest zero
	logic [31:0] m_tdata;
	// [1:0] status
	logic [1:0]  m_tuser;

	bit_timing_t     timing_q [$];
	int              error_count;
	int              send_idle_pct;
	int              recv_stall_pct;
	int              hold_left;
	longint unsigned cycle_count;

	can_bit_timing_search #(
		.MAX_PRESCALER(MAX_PRESCALER),
		.MAX_PHASE2   (MAX_PHASE2)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Exhaustive search over prescalers and phase-2 lengths, first best wins.
	function automatic bit_timing_t search_timing(logic [25:0] osc, logic [20:0] rate,
			logic [9:0] sp_in);
		bit_timing_t     best;
		longint unsigned sp, div, tq, seg1, a, b, err, best_err, best_tq;
		int              brp, seg2;
		bit              found;
		best     = '0;
		best_err = 0;
		best_tq  = 1;
		found    = 1'b0;
		if (osc < cbts_pkg::OSC_MIN || osc > cbts_pkg::OSC_MAX ||
				rate < cbts_pkg::RATE_MIN || rate > cbts_pkg::RATE_MAX ||
				sp_in >= cbts_pkg::SP_LIMIT) begin
			best.status = cbts_pkg::ST_RANGE;
			return best;
		end
		sp = (sp_in == 0) ? cbts_pkg::SP_DEFAULT : sp_in;
		for (brp = 1; brp <= MAX_PRESCALER; brp++) begin
			div = longint'(rate) * brp;
			if (osc % div != 0)
				continue;
			tq = osc / div;
			if (tq < cbts_pkg::TQ_MIN || tq > cbts_pkg::TQ_MAX)
				continue;
			for (seg2 = 1; seg2 <= MAX_PHASE2 && seg2 + 2 < tq; seg2++) begin
				seg1 = tq - seg2 - 1;
				if (seg1 > cbts_pkg::PHASE1_MAX)
					continue;
				a   = (tq - seg2) * cbts_pkg::PERMILL;
				b   = sp * tq;
				err = (a >= b) ? a - b : b - a;
				// compare err/tq against best_err/best_tq without division
				if (found && err * best_tq >= best_err * tq)
					continue;
				found              = 1'b1;
				best_err           = err;
				best_tq            = tq;
				best.prescaler_m1  = 8'(brp - 1);
				best.phase1_m1     = 8'(seg1 - 1);
				best.phase2_m1     = 7'(seg2 - 1);
				best.jump_width_m1 = 7'(((seg2 < seg1) ? seg2 : seg1) - 1);
			end
		end
		if (!found) begin
			best        = '0;
			best.status = cbts_pkg::ST_NOFIT;
		end else begin
			best.status = cbts_pkg::ST_OK;
		end
		return best;
	endfunction

	// Called on a falling edge; returns on the falling edge after the word is taken.
	task automatic send_request(logic [25:0] osc, logic [20:0] rate, logic [9:0] sp);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, sp, rate, osc};
		do
			@(posedge clk);
		while (!s_tready);
		timing_q.push_back(search_timing(osc, rate, sp));
		@(negedge clk);
	endtask

	// Hold the input until every pending result has been checked.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (timing_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Mostly requests built to divide exactly, then plain in-range values, then noise.
	function automatic void pick_request(output logic [25:0] osc, output logic [20:0] rate,
			output logic [9:0] sp);
		longint unsigned prod, top, r, tq;
		int              mode;
		mode = $urandom_range(99);
		sp   = ($urandom_range(9) == 0) ? 10'd0
			: 10'($urandom_range(1, cbts_pkg::SP_LIMIT - 1));
		if (mode < 60) begin
			prod = 0;
			r    = cbts_pkg::RATE_MIN;
			while (prod < cbts_pkg::OSC_MIN) begin
				r   = $urandom_range(1) ? COMMON_RATES[$urandom_range(7)]
				                        : $urandom_range(cbts_pkg::RATE_MIN, 250000);
				tq  = $urandom_range(cbts_pkg::TQ_MIN, cbts_pkg::TQ_MAX);
				top = cbts_pkg::OSC_MAX / (r * tq);
				if (top > MAX_PRESCALER)
					top = MAX_PRESCALER;
				if (top > 0)
					prod = r * tq * $urandom_range(1, int'(top));
			end
			osc  = 26'(prod);
			rate = 21'(r);
		end else if (mode < 80) begin
			osc  = 26'($urandom_range(cbts_pkg::OSC_MIN, cbts_pkg::OSC_MAX));
			rate = 21'($urandom_range(cbts_pkg::RATE_MIN, cbts_pkg::RATE_MAX));
		end else begin
			osc  = 26'($urandom);
			rate = 21'($urandom);
			sp   = 10'($urandom);
		end
	endfunction

	task automatic test_argument_limits();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_request(26'd1999999, 21'd500000, 10'd875);
		send_request(26'd40000001, 21'd500000, 10'd875);
		send_request(26'd0, 21'd0, 10'd0);
		send_request(26'h3FFFFFF, 21'h1FFFFF, 10'h3FF);
		send_request(26'd16000000, 21'd4999, 10'd875);
		send_request(26'd16000000, 21'd1000001, 10'd875);
		send_request(26'd16000000, 21'd500000, 10'd1000);
		send_request(26'd16000000, 21'd500000, 10'd999);
		send_request(26'd2000000, 21'd5000, 10'd1);
		send_request(26'd40000000, 21'd1000000, 10'd0);
		drain_results();
	endtask

	task automatic test_timing_edges();
		// shortest bit: four quanta
		send_request(26'd4000000, 21'd1000000, 10'd500);
		// longest bit: phase 1 limit forces the widest phase 2
		send_request(26'd38500000, 21'd100000, 10'd0);
		send_request(26'd38600000, 21'd100000, 10'd875);
		// no exact division into a legal bit
		send_request(26'd2000000, 21'd1000000, 10'd0);
		send_request(26'd39999999, 21'd999983, 10'd875);
		send_request(26'd20000000, 21'd83333, 10'd800);
		// zero sample point must match an explicit default
		send_request(26'd16000000, 21'd500000, 10'd0);
		send_request(26'd16000000, 21'd500000, 10'd875);
		send_request(26'd40000000, 21'd5000, 10'd750);
		send_request(26'd24000000, 21'd125000, 10'd1);
		send_request(26'd8000000, 21'd250000, 10'd999);
		drain_results();
	endtask

	task automatic test_random_requests(int idle_pct, int stall_pct);
		logic [25:0] osc;
		logic [20:0] rate;
		logic [9:0]  sp;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (RANDOM_ITEMS) begin
			pick_request(osc, rate, sp);
			send_request(osc, rate, sp);
		end
		drain_results();
	endtask

	// Block the output long enough for the input side to back up.
	task automatic test_output_holdoff();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		@(negedge clk);
		repeat (10)
			send_request(26'($urandom_range(0, cbts_pkg::OSC_MIN - 1)), 21'($urandom),
				10'($urandom));
		send_request(26'd16000000, 21'd500000, 10'd0);
		send_request(26'd40000000, 21'd4999, 10'd875);
		drain_results();
	endtask

	initial begin
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		bit_timing_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (timing_q.size() == 0) begin
				$error("result word with nothing pending: tuser %0d tdata %h",
					m_tuser, m_tdata);
				error_count++;
			end else begin
				want = timing_q.pop_front();
				check_field("status", want.status, m_tuser);
				check_field("prescaler_m1", want.prescaler_m1, m_tdata[7:0]);
				check_field("phase1_m1", want.phase1_m1, m_tdata[15:8]);
				check_field("phase2_m1", want.phase2_m1, m_tdata[22:16]);
				check_field("jump_width_m1", want.jump_width_m1, m_tdata[29:23]);
			end
		end
	end

	initial begin
		error_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_argument_limits();
		test_timing_edges();
		test_random_requests(0, 0);
		test_random_requests(56, 0);
		test_random_requests(0, 56);
		test_random_requests(30, 30);
		test_output_holdoff();

		repeat (50) @(posedge clk);
		if (error_count == 0 && timing_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
